// ----- hdl/fcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// fcsg_pkg
// Types and constants shared by the filled circle span generator.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsg_pkg;

    localparam int unsigned MAX_RADIUS = 15;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [3:0]  radius;
        logic [15:0] fill_color;
    } req_t;

    typedef struct packed {
        logic [15:0] span_x;
        logic [15:0] span_y;
        logic [4:0]  span_len;
        logic [15:0] span_color;
        logic        last_span;
    } span_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_OUTER_HI,
        ST_OUTER_LO,
        ST_INNER_HI,
        ST_INNER_LO,
        ST_FLUSH
    } state_t;

    // Last inner row index: r*707/1000 + 1, as a table over the 4-bit radius
    function automatic logic [3:0] imax_of(input logic [3:0] r);
        logic [3:0] v;
        unique case (r)
            4'd0:    v = 4'd1;
            4'd1:    v = 4'd1;
            4'd2:    v = 4'd2;
            4'd3:    v = 4'd3;
            4'd4:    v = 4'd3;
            4'd5:    v = 4'd4;
            4'd6:    v = 4'd5;
            4'd7:    v = 4'd5;
            4'd8:    v = 4'd6;
            4'd9:    v = 4'd7;
            4'd10:   v = 4'd8;
            4'd11:   v = 4'd8;
            4'd12:   v = 4'd9;
            4'd13:   v = 4'd10;
            4'd14:   v = 4'd10;
            default: v = 4'd11;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fcsg_if.sv -----
// ----------------------------------------------------------------------------
// fcsg channel interfaces
// Valid/ready channels for circle requests and generated spans.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcsg_req_if;
    logic          valid;
    logic          ready;
    fcsg_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fcsg_span_if;
    logic           valid;
    logic           ready;
    fcsg_pkg::span_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/filled_circle_span_generator_core.sv -----
// ----------------------------------------------------------------------------
// filled_circle_span_generator_core
// Breaks a filled circle into horizontal spans, one span item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one item per circle (center, radius, color). ready is high only
//          while the sequencer is idle; a zero radius is taken and dropped.
//   span : one item per non-empty span (x, row, length, color); last_span
//          marks the final span of the circle.
//   A small sequencer walks the rows with one shared square/add/compare
//   unit: a radius test per row, a step per candidate span, plus a step
//   to accept and a step to close. The request port stays low until the
//   circle is closed. The first span leaves from the pending register
//   once the next span exists or the circle closes.
//   One span is held back in a pending register until the next one exists,
//   so the last flag is known when it is sent. A real span or the close
//   step waits while an output span is not taken; no span is lost or repeated.
//   Reset (rst_n low, asynchronous) returns the sequencer to idle and
//   empties the pending and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_circle_span_generator_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fcsg_req_if.sink    req,
    fcsg_span_if.source span
);

    fcsg_pkg::state_t state_reg, state_next;

    logic [15:0] cx_reg, cx_next;
    logic [15:0] cy_reg, cy_next;
    logic [15:0] color_reg, color_next;
    logic [3:0]  imax_reg, imax_next;
    logic [7:0]  sqmax_reg, sqmax_next;
    logic [3:0]  x_reg, x_next;
    logic [3:0]  i_reg, i_next;

    logic            pend_valid_reg, pend_valid_next;
    fcsg_pkg::span_t pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    fcsg_pkg::span_t out_reg, out_next;

    logic [3:0]  r_sat;
    logic [8:0]  dist_sq;
    logic        shrink;
    logic        cand_en;
    logic [15:0] cand_x;
    logic [15:0] cand_y;
    logic [4:0]  cand_len;
    logic        out_free;
    logic        advance;
    logic        push;

    assign r_sat = (req.data.radius > 4'(fcsg_pkg::MAX_RADIUS))
                 ? 4'(fcsg_pkg::MAX_RADIUS) : req.data.radius;

    // Shared unit: i*i + x*x against r*r + r/2
    assign dist_sq = {1'b0, {4'd0, i_reg} * {4'd0, i_reg}}
                   + {1'b0, {4'd0, x_reg} * {4'd0, x_reg}};
    assign shrink  = dist_sq > {1'b0, sqmax_reg};

    // Candidate span for the current step
    always_comb
    begin
        cand_en  = 1'b0;
        cand_x   = cx_reg - {12'd0, x_reg};
        cand_y   = cy_reg + {12'd0, i_reg};
        cand_len = {x_reg, 1'b0};
        unique case (state_reg)
            fcsg_pkg::ST_OUTER_HI:
            begin
                cand_en  = 1'b1;
                cand_x   = cx_reg - {12'd0, i_reg} + 16'd1;
                cand_y   = cy_reg + {12'd0, x_reg};
                cand_len = {i_reg - 4'd1, 1'b0};
            end
            fcsg_pkg::ST_OUTER_LO:
            begin
                cand_en  = 1'b1;
                cand_x   = cx_reg - {12'd0, i_reg} + 16'd1;
                cand_y   = cy_reg - {12'd0, x_reg};
                cand_len = {i_reg - 4'd1, 1'b0};
            end
            fcsg_pkg::ST_INNER_HI:
            begin
                cand_en = 1'b1;
            end
            fcsg_pkg::ST_INNER_LO:
            begin
                cand_en = 1'b1;
                cand_y  = cy_reg - {12'd0, i_reg};
            end
            default:
            begin
                cand_en = 1'b0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || span.ready;
    // Empty spans pass at once; a real span needs room to shift the pending one
    assign advance  = (cand_len == 5'd0) || !pend_valid_reg || out_free;
    assign push     = cand_en && (cand_len != 5'd0) && advance;

    always_comb
    begin
        state_next      = state_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        color_next      = color_reg;
        imax_next       = imax_reg;
        sqmax_next      = sqmax_reg;
        x_next          = x_reg;
        i_next          = i_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !span.ready;
        out_next        = out_reg;
        req.ready       = 1'b0;

        if (push)
        begin
            pend_valid_next     = 1'b1;
            pend_next.span_x     = cand_x;
            pend_next.span_y     = cand_y;
            pend_next.span_len   = cand_len;
            pend_next.span_color = color_reg;
            pend_next.last_span  = 1'b0;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
            end
        end

        unique case (state_reg)
            fcsg_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && r_sat != 4'd0)
                begin
                    cx_next              = req.data.center_x;
                    cy_next              = req.data.center_y;
                    color_next           = req.data.fill_color;
                    imax_next            = fcsg_pkg::imax_of(r_sat);
                    sqmax_next           = ({4'd0, r_sat} * {4'd0, r_sat})
                                         + {5'd0, r_sat[3:1]};
                    x_next               = r_sat;
                    i_next               = 4'd1;
                    // Center row goes straight to pending
                    pend_valid_next      = 1'b1;
                    pend_next.span_x     = req.data.center_x - {12'd0, r_sat};
                    pend_next.span_y     = req.data.center_y;
                    pend_next.span_len   = {r_sat, 1'b0};
                    pend_next.span_color = req.data.fill_color;
                    pend_next.last_span  = 1'b0;
                    state_next           = fcsg_pkg::ST_TEST;
                end
            end
            fcsg_pkg::ST_TEST:
            begin
                if (shrink && x_reg > imax_reg)
                begin
                    state_next = fcsg_pkg::ST_OUTER_HI;
                end
                else
                begin
                    if (shrink && x_reg != 4'd0)
                    begin
                        x_next = x_reg - 4'd1;
                    end
                    state_next = fcsg_pkg::ST_INNER_HI;
                end
            end
            fcsg_pkg::ST_OUTER_HI:
            begin
                if (advance)
                begin
                    state_next = fcsg_pkg::ST_OUTER_LO;
                end
            end
            fcsg_pkg::ST_OUTER_LO:
            begin
                if (advance)
                begin
                    // x is above imax here, so it never underflows
                    x_next     = x_reg - 4'd1;
                    state_next = fcsg_pkg::ST_INNER_HI;
                end
            end
            fcsg_pkg::ST_INNER_HI:
            begin
                if (advance)
                begin
                    state_next = fcsg_pkg::ST_INNER_LO;
                end
            end
            fcsg_pkg::ST_INNER_LO:
            begin
                if (advance)
                begin
                    i_next = i_reg + 4'd1;
                    if (i_reg == imax_reg)
                    begin
                        state_next = fcsg_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        state_next = fcsg_pkg::ST_TEST;
                    end
                end
            end
            fcsg_pkg::ST_FLUSH:
            begin
                // Release the held span with the last flag
                if (!pend_valid_reg)
                begin
                    state_next = fcsg_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next           = pend_reg;
                    out_next.last_span = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = fcsg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fcsg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fcsg_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        color_reg <= color_next;
        imax_reg  <= imax_next;
        sqmax_reg <= sqmax_next;
        x_reg     <= x_next;
        i_reg     <= i_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    assign span.valid = out_valid_reg;
    assign span.data  = out_reg;

endmodule

`default_nettype wire

// ----- tb/sv/fcsg_span_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcsg_span_checker
// Watches the circle request and span channels of the filled circle span
// generator. Works out the spans of every accepted circle and compares each
// accepted span, field by field, against the oldest outstanding one.
// ----------------------------------------------------------------------------
module fcsg_span_checker (
    input  logic clk,
    input  logic rst_n,
    fcsg_req_if  req,
    fcsg_span_if span,
    output int   mismatches,
    output int   owed
);

    fcsg_pkg::span_t expected_spans[$];

    // Drop empty spans; coordinates wrap to 16 bits.
    function automatic void push_span(input int x, input int y, input int len,
                                      input logic [15:0] color);
        fcsg_pkg::span_t s;
        if (len == 0)
            return;
        s.span_x     = 16'(x);
        s.span_y     = 16'(y);
        s.span_len   = 5'(len);
        s.span_color = color;
        s.last_span  = 1'b0;
        expected_spans.push_back(s);
    endfunction

    function automatic void predict_circle_spans(input fcsg_pkg::req_t c);
        int cx, cy, r, row_limit, sq_limit, half_w, base_count;
        cx = c.center_x;
        cy = c.center_y;
        r  = c.radius;
        if (r > fcsg_pkg::MAX_RADIUS)
            r = fcsg_pkg::MAX_RADIUS;
        if (r == 0)
            return;
        base_count = expected_spans.size();
        row_limit  = r * 707 / 1000 + 1;
        sq_limit   = r * r + r / 2;
        half_w     = r;
        push_span(cx - r, cy, 2 * r, c.fill_color);
        for (int i = 1; i <= row_limit; i++)
        begin
            if (i * i + half_w * half_w > sq_limit)
            begin
                // rows beyond the octant boundary get their spans here
                if (half_w > row_limit)
                begin
                    push_span(cx - i + 1, cy + half_w, 2 * (i - 1), c.fill_color);
                    push_span(cx - i + 1, cy - half_w, 2 * (i - 1), c.fill_color);
                end
                if (half_w > 0)
                    half_w--;
            end
            push_span(cx - half_w, cy + i, 2 * half_w, c.fill_color);
            push_span(cx - half_w, cy - i, 2 * half_w, c.fill_color);
        end
        if (expected_spans.size() > base_count)
            expected_spans[expected_spans.size() - 1].last_span = 1'b1;
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: span %s mismatch: expected %h, got %h",
                     $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        fcsg_pkg::span_t got, want;
        if (!rst_n)
        begin
            mismatches = 0;
            owed      <= 0;
            expected_spans.delete();
        end
        else
        begin
            // retire spans first: a span never belongs to a circle taken at the same edge
            if (span.valid && span.ready)
            begin
                got = span.data;
                if (expected_spans.size() == 0)
                begin
                    $display("%0t: unexpected span: expected none, got x=%h y=%h len=%0d",
                             $time, got.span_x, got.span_y, got.span_len);
                    $display("%0t:   color=%h last=%b",
                             $time, got.span_color, got.last_span);
                    mismatches++;
                end
                else
                begin
                    want = expected_spans.pop_front();
                    check_field("x", want.span_x, got.span_x);
                    check_field("y", want.span_y, got.span_y);
                    check_field("len", 16'(want.span_len), 16'(got.span_len));
                    check_field("color", want.span_color, got.span_color);
                    check_field("last", 16'(want.last_span), 16'(got.last_span));
                end
            end
            if (req.valid && req.ready)
                predict_circle_spans(req.data);
            owed <= expected_spans.size();
        end
    end

endmodule

// ----- tb/sv/tb_filled_circle_span_generator_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_filled_circle_span_generator_core
// Drives circle requests into the span generator and takes its spans with
// random stalls. A directed run covers every radius and the wrap points of
// the coordinates, then random circles follow with idle gaps, a stretch
// without gaps, a long output stall and a drain pause. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_filled_circle_span_generator_core;

    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_CIRCLES  = 250;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int QUIET_LIMIT     = 1500;
    localparam int DRAIN_CYCLES    = 60;

    logic clk = 1'b0;
    logic rst_n;
    logic sender_idles;
    logic sink_idles;
    logic hold_off_go;
    int   span_mismatches;
    int   spans_owed;

    fcsg_req_if  req_if();
    fcsg_span_if span_if();

    filled_circle_span_generator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .span  (span_if)
    );

    fcsg_span_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .span       (span_if),
        .mismatches (span_mismatches),
        .owed       (spans_owed)
    );

    always #2 clk = ~clk;

    function automatic fcsg_pkg::req_t circle(input logic [15:0] cx,
                                              input logic [15:0] cy,
                                              input logic [3:0] r,
                                              input logic [15:0] color);
        fcsg_pkg::req_t c;
        c.center_x   = cx;
        c.center_y   = cy;
        c.radius     = r;
        c.fill_color = color;
        return c;
    endfunction

    function automatic fcsg_pkg::req_t random_circle();
        fcsg_pkg::req_t c;
        c.center_x   = 16'($urandom);
        c.center_y   = 16'($urandom);
        c.fill_color = 16'($urandom);
        // pull the center next to the wrap point now and then
        if ($urandom_range(3) == 0)
            c.center_x = 16'($urandom_range(31)) - 16'd16;
        if ($urandom_range(3) == 0)
            c.center_y = 16'($urandom_range(31)) - 16'd16;
        if ($urandom_range(24) == 0)
            c.radius = 4'd0;
        else
            c.radius = 4'($urandom_range(1, 15));
        return c;
    endfunction

    // Hold valid high across back-to-back items; lower it only for a gap.
    task automatic send_circle(input fcsg_pkg::req_t c);
        while (sender_idles && $urandom_range(99) < 11)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= c;
        do @(posedge clk); while (!req_if.ready);
    endtask

    task automatic wait_for_spans();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (spans_owed != 0)
            @(posedge clk);
    endtask

    initial
    begin : span_sink
        logic hold_off_done;
        hold_off_done = 1'b0;
        span_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_go && !hold_off_done)
            begin
                span_if.ready <= 1'b0;
                hold_off_done = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                span_if.ready <= !(sink_idles && $urandom_range(99) < 11);
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (span_if.valid && span_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        fcsg_pkg::req_t c;
        int             n;
        rst_n         = 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        sender_idles  = 1'b1;
        sink_idles   <= 1'b1;
        hold_off_go  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero radius is taken and dropped
        send_circle(circle(16'd100, 16'd100, 4'd0, 16'h1234));
        for (int r = 1; r <= 15; r++)
            send_circle(circle(16'(r * 4099), 16'(65535 - r * 3001), 4'(r),
                               16'(r * 16'h1111)));
        send_circle(circle(16'h0000, 16'h0000, 4'd15, 16'hFFFF));
        send_circle(circle(16'hFFFF, 16'hFFFF, 4'd15, 16'h0000));
        send_circle(circle(16'h0000, 16'hFFFF, 4'd1, 16'hAAAA));
        send_circle(circle(16'hFFFF, 16'h0000, 4'd2, 16'h5555));
        send_circle(circle(16'h7FFF, 16'h8000, 4'd15, 16'h8001));
        wait_for_spans();

        n = 0;
        while (n < RANDOM_CIRCLES)
        begin
            if (n == 80)
            begin
                sender_idles = 1'b0;
                sink_idles  <= 1'b0;
            end
            if (n == 140)
            begin
                sender_idles = 1'b1;
                sink_idles  <= 1'b1;
            end
            // stall the output and keep offering circles
            if (n == 160)
                hold_off_go <= 1'b1;
            if (n == 220)
                wait_for_spans();
            c = random_circle();
            send_circle(c);
            if (c.radius != 4'd0)
                n++;
        end

        wait_for_spans();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (span_mismatches == 0 && spans_owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
